### hdl/ssp_pkg.sv
`default_nettype none

package ssp_pkg;

    localparam int VID_W            = 6;
    localparam int WT_W             = 16;
    localparam int DIST_W           = 32;
    localparam int DIST_DEPTH       = 64;
    localparam int DEF_MAX_VERTICES = 63;
    localparam int DEF_MAX_EDGES    = 1024;
    localparam int CFG_AW           = 1;
    localparam int CFG_DW           = 6;

    localparam logic signed [DIST_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DIST_W-1:0] INT_MIN = 32'sh8000_0000;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_VERTEX_COUNT  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_SOURCE_VERTEX = 1'b1;

    typedef struct packed {
        logic [WT_W-1:0]  weight;
        logic [VID_W-1:0] to_v;
        logic [VID_W-1:0] from_v;
    } edge_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DIST_W-1:0] val;
    } dist_entry_t;

    typedef struct packed {
        logic             we;
        logic [VID_W-1:0] waddr;
        dist_entry_t      wdata;
        logic [VID_W-1:0] raddr_a;
        logic [VID_W-1:0] raddr_b;
    } dist_req_t;

    function automatic logic signed [DIST_W-1:0] sat_add(
        input logic signed [DIST_W-1:0] a,
        input logic signed [WT_W-1:0]   w
    );
        logic signed [DIST_W:0] s;
        s = {a[DIST_W-1], a} + {{(DIST_W-WT_W+1){w[WT_W-1]}}, w};
        if (s[DIST_W] != s[DIST_W-1]) begin
            return s[DIST_W] ? INT_MIN : INT_MAX;
        end
        return s[DIST_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/ssp_edge_mem.sv
`default_nettype none

module ssp_edge_mem
    import ssp_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_EDGES,
    parameter int AW    = 10
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire edge_t         wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output edge_t              rdata
);

    edge_t mem [DEPTH];
    edge_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hdl/ssp_dist_mem.sv
`default_nettype none

module ssp_dist_mem
    import ssp_pkg::*;
(
    input  wire logic      aclk,
    input  wire dist_req_t req,
    output dist_entry_t    rdata_a,
    output dist_entry_t    rdata_b
);

    dist_entry_t mem [DIST_DEPTH];
    dist_entry_t rdata_a_reg;
    dist_entry_t rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_a_reg <= mem[req.raddr_a];
        rdata_b_reg <= mem[req.raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

### hdl/single_source_shortest_path_engine_unit.sv
// edges load at one transfer per cycle while idle; the final edge starts a run that
//   clears all 64 distance store entries, then makes one pass per vertex over the
//   stored edges, the last a check pass, each edge going through S_RD_DIST and S_RELAX
// then one result per vertex as the output frees, or a single negative-cycle result
// no input is taken from the final edge until the last result sits in the output register
// reset (aresetn low, synchronous): idle, no stored edges, vertex_count 1, source 0
`default_nettype none

module single_source_shortest_path_engine_unit
    import ssp_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CFG_DW-1:0] cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,   // edge_from, edge_to, edge_weight
    input  wire logic              s_tlast,   // final_edge
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [39:0]            m_tdata,   // vertex_id, distance
    output logic [1:0]             m_tuser,   // unreachable, negative_cycle
    output logic                   m_tlast    // run_end
);

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_RD_DIST, S_RELAX, S_NEG, S_OUT_RD, S_OUT_LOAD
    } state_t;

    state_t                   state_reg;
    logic [VID_W-1:0]         vertex_count_reg;
    logic [VID_W-1:0]         source_vertex_reg;
    logic [VID_W-1:0]         vc_run_reg;
    logic [VID_W-1:0]         src_run_reg;
    logic [ECW-1:0]           edge_total_reg;
    logic [ECW-1:0]           edge_idx_reg;
    logic [ECW-1:0]           edge_idx_next;
    logic [VID_W-1:0]         pass_reg;
    logic [VID_W-1:0]         clr_reg;
    logic [VID_W-1:0]         k_reg;
    logic                     any_reg;
    logic                     m_valid_reg;
    logic [VID_W-1:0]         m_vid_reg;
    logic signed [DIST_W-1:0] m_dist_reg;
    logic                     m_unreach_reg;
    logic                     m_neg_reg;
    logic                     m_last_reg;

    logic                     in_fire;
    logic                     out_free;
    logic [VID_W-1:0]         vc_eff;
    logic                     edge_we;
    logic                     edge_re;
    logic [EAW-1:0]           edge_raddr;
    edge_t                    edge_in;
    edge_t                    edge_rd;
    dist_req_t                dist_req;
    dist_entry_t              du;
    dist_entry_t              dv;
    logic signed [DIST_W-1:0] cand;
    logic                     relax_hit;
    logic                     is_check;
    logic                     edge_last;

    always_comb begin
        s_tready  = (state_reg == S_IDLE);
        in_fire   = s_tvalid && s_tready;
        out_free  = !m_valid_reg || m_tready;
        edge_in   = '{weight: s_tdata[27:12], to_v: s_tdata[11:6], from_v: s_tdata[5:0]};
        edge_we   = in_fire && (edge_total_reg < ECW'(MAX_EDGES));

        if (vertex_count_reg == '0) begin
            vc_eff = VID_W'(1);
        end else if (vertex_count_reg > VID_W'(MAX_VERTICES)) begin
            vc_eff = VID_W'(MAX_VERTICES);
        end else begin
            vc_eff = vertex_count_reg;
        end

        edge_last     = ((edge_idx_reg + ECW'(1)) == edge_total_reg);
        edge_idx_next = edge_last ? '0 : edge_idx_reg + ECW'(1);
        edge_re       = (state_reg == S_CLEAR) || (state_reg == S_RELAX);
        edge_raddr    = (state_reg == S_RELAX) ? edge_idx_next[EAW-1:0]
                                               : edge_idx_reg[EAW-1:0];

        cand      = sat_add(du.val, edge_rd.weight);
        relax_hit = du.ok && (!dv.ok || (dv.val > cand));
        is_check  = (pass_reg == (vc_run_reg - VID_W'(1)));

        dist_req         = '0;
        dist_req.raddr_a = edge_rd.from_v;
        dist_req.raddr_b = edge_rd.to_v;
        case (state_reg)
            S_CLEAR: begin
                dist_req.we          = 1'b1;
                dist_req.waddr       = clr_reg;
                dist_req.wdata.ok    = (clr_reg == src_run_reg);
                dist_req.wdata.val   = '0;
            end
            S_RELAX: begin
                // check pass only looks, never writes
                dist_req.we          = relax_hit && !is_check;
                dist_req.waddr       = edge_rd.to_v;
                dist_req.wdata.ok    = 1'b1;
                dist_req.wdata.val   = cand;
            end
            S_OUT_RD: begin
                dist_req.raddr_a     = k_reg;
            end
            default: begin
            end
        endcase
    end

    ssp_edge_mem #(
        .DEPTH (MAX_EDGES),
        .AW    (EAW)
    ) u_edge_mem (
        .aclk  (aclk),
        .we    (edge_we),
        .waddr (edge_total_reg[EAW-1:0]),
        .wdata (edge_in),
        .re    (edge_re),
        .raddr (edge_raddr),
        .rdata (edge_rd)
    );

    ssp_dist_mem u_dist_mem (
        .aclk    (aclk),
        .req     (dist_req),
        .rdata_a (du),
        .rdata_b (dv)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            vertex_count_reg  <= VID_W'(1);
            source_vertex_reg <= '0;
            edge_total_reg    <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_VERTEX_COUNT:  vertex_count_reg  <= cfg_wdata;
                    CFG_SOURCE_VERTEX: source_vertex_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end

            // the negative-cycle state reloads the register itself
            if (m_valid_reg && m_tready && (state_reg != S_NEG)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        if (edge_we) begin
                            edge_total_reg <= edge_total_reg + ECW'(1);
                        end
                        if (s_tlast) begin
                            vc_run_reg   <= vc_eff;
                            src_run_reg  <= source_vertex_reg;
                            clr_reg      <= '0;
                            edge_idx_reg <= '0;
                            pass_reg     <= '0;
                            any_reg      <= 1'b0;
                            state_reg    <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR: begin
                    clr_reg <= clr_reg + VID_W'(1);
                    if (clr_reg == VID_W'(DIST_DEPTH - 1)) begin
                        state_reg <= S_RD_DIST;
                    end
                end
                S_RD_DIST: begin
                    state_reg <= S_RELAX;
                end
                S_RELAX: begin
                    edge_idx_reg <= edge_idx_next;
                    if (relax_hit && is_check) begin
                        any_reg <= 1'b1;
                    end
                    if (!edge_last) begin
                        state_reg <= S_RD_DIST;
                    end else if (!is_check) begin
                        pass_reg  <= pass_reg + VID_W'(1);
                        state_reg <= S_RD_DIST;
                    end else if (any_reg || relax_hit) begin
                        state_reg <= S_NEG;
                    end else begin
                        k_reg     <= VID_W'(1);
                        state_reg <= S_OUT_RD;
                    end
                end
                S_NEG: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_vid_reg      <= '0;
                        m_dist_reg     <= '0;
                        m_unreach_reg  <= 1'b0;
                        m_neg_reg      <= 1'b1;
                        m_last_reg     <= 1'b1;
                        edge_total_reg <= '0;
                        state_reg      <= S_IDLE;
                    end
                end
                S_OUT_RD: begin
                    // move on only once the output register frees up
                    if (out_free) begin
                        state_reg <= S_OUT_LOAD;
                    end
                end
                S_OUT_LOAD: begin
                    m_valid_reg   <= 1'b1;
                    m_vid_reg     <= k_reg;
                    m_dist_reg    <= du.ok ? du.val : INT_MAX;
                    m_unreach_reg <= !du.ok;
                    m_neg_reg     <= 1'b0;
                    m_last_reg    <= (k_reg == vc_run_reg);
                    k_reg         <= k_reg + VID_W'(1);
                    if (k_reg == vc_run_reg) begin
                        edge_total_reg <= '0;
                        state_reg      <= S_IDLE;
                    end else begin
                        state_reg <= S_OUT_RD;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_dist_reg, m_vid_reg};
    assign m_tuser  = {m_neg_reg, m_unreach_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_load_into_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT_LOAD) |-> !m_valid_reg)
        else $error("result loaded over a pending transfer");

    a_edge_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        edge_total_reg <= ECW'(MAX_EDGES))
        else $error("edge count beyond store depth");

    a_edge_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RELAX) |-> (edge_idx_reg < edge_total_reg))
        else $error("relaxing past the stored edges");

    a_neg_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_neg_reg) |-> (m_last_reg && !m_unreach_reg))
        else $error("negative-cycle result not marked as run end");

    a_write_only_when_working: assert property (@(posedge aclk) disable iff (!aresetn)
        dist_req.we |-> ((state_reg == S_CLEAR) || ((state_reg == S_RELAX) && !is_check)))
        else $error("distance store written outside init or relaxation");
`endif

endmodule

`default_nettype wire

### test/single_source_shortest_path_engine_unit_test.sv
`timescale 1ns / 1ps

module single_source_shortest_path_engine_unit_test;

    import ssp_pkg::*;

    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int RANDOM_ITEMS    = 315;

    typedef struct packed {
        logic  last;
        edge_t arc;
    } edge_item_t;

    typedef struct packed {
        logic [VID_W-1:0]         vertex;
        logic signed [DIST_W-1:0] distance;
        logic                     unreachable;
        logic                     neg_cycle;
        logic                     run_end;
    } path_result_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CFG_AW-1:0] cfg_addr  = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;   // edge_from, edge_to, edge_weight
    logic              s_tlast   = 1'b0; // final_edge
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [39:0]       m_tdata;          // vertex_id, distance
    logic [1:0]        m_tuser;          // unreachable, negative_cycle
    logic              m_tlast;          // run_end

    single_source_shortest_path_engine_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #10 aclk = ~aclk;

    // predictor state
    edge_t             edge_mem [DEF_MAX_EDGES];
    int unsigned       edge_count       = 0;
    longint            path_len [DIST_DEPTH];
    bit                path_known [DIST_DEPTH];
    logic [CFG_DW-1:0] vertex_count_reg = 1;
    logic [CFG_DW-1:0] source_reg       = 0;
    path_result_t      pending_paths [$];

    // stimulus and bookkeeping
    edge_item_t edge_queue [$];
    edge_item_t next_edge;
    int         items_queued  = 0;
    int         edges_taken   = 0;
    int         results_seen  = 0;
    int         runs_seen     = 0;
    int         neg_seen      = 0;
    int         mismatches    = 0;
    int         cycle_count   = 0;
    int         send_wait     = 0;
    int         recv_wait     = 0;
    int         stall_draw;
    int         hold_count    = 0;
    bit         hold_off_req  = 1'b0;
    bit         hold_off_done = 1'b0;
    bit         sender_calm   = 1'b0;
    bit         receiver_calm = 1'b0;
    bit         edge_taken    = 1'b0;
    bit         result_taken  = 1'b0;

    function automatic longint clamp_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (s > longint'(INT_MAX)) return longint'(INT_MAX);
        if (s < longint'(INT_MIN)) return longint'(INT_MIN);
        return s;
    endfunction

    // one sweep over the stored edges in load order
    function automatic bit relax_edges(bit apply);
        bit     changed;
        longint cand;
        edge_t  e;
        int     i;
        changed = 1'b0;
        for (i = 0; i < int'(edge_count); i++) begin
            e = edge_mem[i];
            if (path_known[e.from_v]) begin
                cand = clamp_sum(path_len[e.from_v], longint'($signed(e.weight)));
                if (!path_known[e.to_v] || path_len[e.to_v] > cand) begin
                    changed = 1'b1;
                    if (apply) begin
                        path_known[e.to_v] = 1'b1;
                        path_len[e.to_v]   = cand;
                    end
                end
            end
        end
        return changed;
    endfunction

    task automatic accept_edge(input edge_t e, input bit last);
        int           vc;
        int           p;
        int           k;
        path_result_t r;
        if (edge_count < DEF_MAX_EDGES) begin
            edge_mem[edge_count] = e;
            edge_count++;
        end
        if (!last) return;
        vc = vertex_count_reg;
        if (vc == 0) vc = 1;
        if (vc > DEF_MAX_VERTICES) vc = DEF_MAX_VERTICES;
        for (k = 0; k < DIST_DEPTH; k++) begin
            path_known[k] = 1'b0;
            path_len[k]   = 0;
        end
        path_known[source_reg] = 1'b1;
        for (p = 1; p < vc; p++) void'(relax_edges(1'b1));
        if (relax_edges(1'b0)) begin
            r.vertex      = '0;
            r.distance    = '0;
            r.unreachable = 1'b0;
            r.neg_cycle   = 1'b1;
            r.run_end     = 1'b1;
            pending_paths.insert(pending_paths.size(), r);
        end else begin
            for (k = 1; k <= vc; k++) begin
                r.vertex      = VID_W'(k);
                r.distance    = path_known[k] ? DIST_W'(path_len[k]) : INT_MAX;
                r.unreachable = !path_known[k];
                r.neg_cycle   = 1'b0;
                r.run_end     = (k == vc);
                pending_paths.insert(pending_paths.size(), r);
            end
        end
        edge_count = 0;
    endtask

    task automatic check_result();
        path_result_t             want;
        logic [VID_W-1:0]         got_vertex;
        logic signed [DIST_W-1:0] got_distance;
        got_vertex   = m_tdata[VID_W-1:0];
        got_distance = m_tdata[VID_W+DIST_W-1:VID_W];
        results_seen++;
        if (m_tuser[1]) neg_seen++;
        if (m_tlast) runs_seen++;
        if (pending_paths.size() == 0) begin
            $error("unexpected result transfer: vertex_id %0d distance %0d",
                   got_vertex, got_distance);
            mismatches++;
            return;
        end
        want = pending_paths.pop_front();
        if (got_vertex !== want.vertex) begin
            $error("vertex_id mismatch: expected %0d, actual %0d", want.vertex, got_vertex);
            mismatches++;
        end
        if (got_distance !== want.distance) begin
            $error("distance mismatch: expected %0d, actual %0d", want.distance, got_distance);
            mismatches++;
        end
        if (m_tuser[0] !== want.unreachable) begin
            $error("unreachable mismatch: expected %0d, actual %0d",
                   want.unreachable, m_tuser[0]);
            mismatches++;
        end
        if (m_tuser[1] !== want.neg_cycle) begin
            $error("negative_cycle mismatch: expected %0d, actual %0d",
                   want.neg_cycle, m_tuser[1]);
            mismatches++;
        end
        if (m_tlast !== want.run_end) begin
            $error("run_end mismatch: expected %0d, actual %0d", want.run_end, m_tlast);
            mismatches++;
        end
    endtask

    // monitor: sample both channels at the rising edge
    always @(posedge aclk) begin
        edge_taken   <= aresetn && s_tvalid && s_tready;
        result_taken <= aresetn && m_tvalid && m_tready;
        if (aresetn && m_tvalid && m_tready) begin
            check_result();
        end
        if (aresetn && s_tvalid && s_tready) begin
            accept_edge(edge_t'(s_tdata[27:0]), s_tlast);
            edges_taken++;
        end
    end

    // driver: feed edges from the queue with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || edge_taken) begin
            if (send_wait > 0) begin
                s_tvalid  <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (edge_queue.size() != 0) begin
                next_edge = edge_queue.pop_front();
                s_tdata   <= {4'b0, next_edge.arc};
                s_tlast   <= next_edge.last;
                s_tvalid  <= 1'b1;
                send_wait <= sender_calm ? 0 : $urandom_range(0, 12);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stall per result, plus one long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_req && !hold_off_done) begin
            m_tready <= 1'b0;
            // count only while a result is actually held back
            if (hold_count == HOLD_OFF_CYCLES) begin
                hold_off_done <= 1'b1;
            end else if (m_tvalid) begin
                hold_count <= hold_count + 1;
            end
        end else if (result_taken && !receiver_calm) begin
            stall_draw = $urandom_range(0, 12);
            m_tready  <= (stall_draw == 0);
            recv_wait <= (stall_draw == 0) ? 0 : stall_draw - 1;
        end else if (recv_wait > 0) begin
            m_tready  <= 1'b0;
            recv_wait <= recv_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timeout with %0d results outstanding", pending_paths.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_edge(input int from_v, input int to_v, input int weight,
                             input bit last);
        edge_item_t item;
        item.arc.from_v = VID_W'(from_v);
        item.arc.to_v   = VID_W'(to_v);
        item.arc.weight = WT_W'(weight);
        item.last       = last;
        edge_queue.insert(edge_queue.size(), item);
        items_queued++;
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input int value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DW'(value);
        @(posedge aclk);
        if (idx == CFG_VERTEX_COUNT) begin
            vertex_count_reg = CFG_DW'(value);
        end else begin
            source_reg = CFG_DW'(value);
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int vc, input int src);
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_VERTEX_COUNT, vc);
            write_reg(CFG_SOURCE_VERTEX, src);
        end else begin
            write_reg(CFG_SOURCE_VERTEX, src);
            write_reg(CFG_VERTEX_COUNT, vc);
        end
    endtask

    // all edges taken and all distances back, then let the block settle
    task automatic drain();
        while (edges_taken != items_queued || pending_paths.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic queue_random_run(input int span, input int src, output int count);
        int n;
        int i;
        int from_v;
        int to_v;
        int w;
        int pick;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 12);
        from_v = src;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                // noise edge anywhere in the id space
                push_edge($urandom_range(0, 63), $urandom_range(0, 63),
                          int'($urandom_range(0, 65535)) - 32768, i == n - 1);
            end else begin
                if ($urandom_range(0, 2) == 0) from_v = $urandom_range(0, span);
                to_v = $urandom_range(0, span);
                pick = $urandom_range(0, 19);
                if (pick < 12) begin
                    w = $urandom_range(0, 500);
                end else if (pick < 16) begin
                    w = int'($urandom_range(0, 300)) - 60;
                end else if (pick < 18) begin
                    w = int'($urandom_range(0, 65535)) - 32768;
                end else if (pick == 18) begin
                    w = 32767;
                end else begin
                    w = -32768;
                end
                push_edge(from_v, to_v, w, i == n - 1);
                from_v = to_v;
            end
        end
        count = n;
    endtask

    initial begin
        int vc;
        int vc_eff;
        int src;
        int runs;
        int count;
        int random_items;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset values: one vertex, source zero; tail never reached
        push_edge(63, 63, -32768, 1'b1);
        drain();

        // vertex count of zero acts as one; self loop of weight zero
        set_config(0, 1);
        push_edge(1, 1, 0, 1'b0);
        push_edge(0, 1, 7, 1'b1);
        drain();

        // widest graph with extreme weights and ids above the chain
        set_config(63, 0);
        push_edge(0, 1, 32767, 1'b0);
        push_edge(1, 2, -32768, 1'b0);
        push_edge(2, 63, 7, 1'b0);
        push_edge(63, 5, 1, 1'b0);
        push_edge(5, 62, -1, 1'b1);
        drain();

        // reachable negative cycle next to an unreachable negative edge
        set_config(3, 2);
        push_edge(2, 3, -1, 1'b0);
        push_edge(0, 1, -32768, 1'b0);
        push_edge(3, 2, -1, 1'b1);
        drain();

        // source above vertex_count
        set_config(5, 63);
        push_edge(63, 1, 100, 1'b0);
        push_edge(1, 4, -50, 1'b0);
        push_edge(4, 5, 0, 1'b1);
        drain();

        // single vertex graph, source 63, edge out of the source
        set_config(1, 63);
        push_edge(63, 0, 3, 1'b1);
        drain();

        // receiver holds off while two runs are offered back to back
        set_config(6, 0);
        hold_off_req = 1'b1;
        queue_random_run(6, 0, count);
        queue_random_run(6, 0, count);
        drain();

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: vc = 63;
                1: vc = $urandom_range(0, 1);
                2: vc = $urandom_range(13, 62);
                default: vc = $urandom_range(2, 12);
            endcase
            vc_eff = (vc == 0) ? 1 : vc;
            src = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(0, vc_eff);
            set_config(vc, src);
            sender_calm   = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
            runs = $urandom_range(1, 3);
            repeat (runs) begin
                queue_random_run(vc_eff, src, count);
                random_items += count;
            end
            drain();
        end
        repeat (40) @(posedge aclk);

        $display("edge transfers: %0d, runs finished: %0d, result transfers: %0d",
                 edges_taken, runs_seen, results_seen);
        $display("negative-cycle reports: %0d, plus a long receiver hold-off", neg_seen);
        if (mismatches == 0 && pending_paths.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/ssp_pkg.sv
hdl/ssp_edge_mem.sv
hdl/ssp_dist_mem.sv
hdl/single_source_shortest_path_engine_unit.sv
test/single_source_shortest_path_engine_unit_test.sv
